### rtl/bpb_pkg.sv
// Shared types and constants for the binary to packed BCD converter.
`default_nettype none

package bpb_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 4;
  localparam int BYTE_BITS  = 8;
  localparam int DIGIT_BITS = 4;
  localparam int ADJ_LIMIT  = 5;
  localparam int ADJ_ADD    = 3;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] byte_count;
  } bin_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] bcd_byte;
    logic                 last;
  } bcd_item_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_DONE
  } cv_state_t;

endpackage

`default_nettype wire

### rtl/bpb_dabble.sv
// Bit-serial double dabble converter: one binary bit enters the BCD register per cycle.
`default_nettype none

module bpb_dabble #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_BYTES   = 8,
  localparam int DW  = 2 * MAX_BYTES * bpb_pkg::DIGIT_BITS,
  localparam int NBW = $clog2(MAX_BYTES + 1),
  localparam int CW  = $clog2(VALUE_WIDTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                bin_valid,
  output logic                bin_stall,
  input  bpb_pkg::bin_item_t  bin_item,
  output logic                hand_valid,
  input  logic                hand_ready,
  output logic [DW-1:0]       hand_digits,
  output logic [NBW-1:0]      hand_count
);

  localparam int DIGITS = 2 * MAX_BYTES;

  bpb_pkg::cv_state_t state, state_next;
  logic [VALUE_WIDTH-1:0] bin, bin_next;
  logic [DW-1:0]          bcd, bcd_next;
  logic [DW-1:0]          adj;
  logic [CW-1:0]          cnt, cnt_next;
  logic [NBW-1:0]         count, count_next;
  logic [NBW-1:0]         count_sat;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*bpb_pkg::DIGIT_BITS +: bpb_pkg::DIGIT_BITS] >=
          bpb_pkg::DIGIT_BITS'(bpb_pkg::ADJ_LIMIT)) begin
        adj[d*bpb_pkg::DIGIT_BITS +: bpb_pkg::DIGIT_BITS] =
          bcd[d*bpb_pkg::DIGIT_BITS +: bpb_pkg::DIGIT_BITS] +
          bpb_pkg::DIGIT_BITS'(bpb_pkg::ADJ_ADD);
      end else begin
        adj[d*bpb_pkg::DIGIT_BITS +: bpb_pkg::DIGIT_BITS] =
          bcd[d*bpb_pkg::DIGIT_BITS +: bpb_pkg::DIGIT_BITS];
      end
    end
  end

  assign count_sat = ({1'b0, bin_item.byte_count} > (bpb_pkg::COUNT_BITS + 1)'(MAX_BYTES)) ?
                     NBW'(MAX_BYTES) : NBW'(bin_item.byte_count);

  always_comb begin
    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    count_next = count;
    bin_stall  = 1'b1;
    hand_valid = 1'b0;
    unique case (state)
      bpb_pkg::CV_IDLE: begin
        bin_stall = 1'b0;
        if (bin_valid && bin_item.byte_count != '0) begin
          state_next = bpb_pkg::CV_SHIFT;
          bin_next   = VALUE_WIDTH'(bin_item.value);
          bcd_next   = '0;
          cnt_next   = CW'(VALUE_WIDTH - 1);
          count_next = count_sat;
        end
      end
      bpb_pkg::CV_SHIFT: begin
        bcd_next = {adj[DW-2:0], bin[VALUE_WIDTH-1]};
        bin_next = bin << 1;
        if (cnt == '0) begin
          state_next = bpb_pkg::CV_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      bpb_pkg::CV_DONE: begin
        hand_valid = 1'b1;
        if (hand_ready) begin
          state_next = bpb_pkg::CV_IDLE;
        end
      end
      default: begin
        state_next = bpb_pkg::CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpb_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bin   <= bin_next;
    bcd   <= bcd_next;
    cnt   <= cnt_next;
    count <= count_next;
  end

  assign hand_digits = bcd;
  assign hand_count  = count;

  a_shift_ends: assert property (@(posedge clk) disable iff (rst)
    state == bpb_pkg::CV_SHIFT && cnt == '0 |=> state == bpb_pkg::CV_DONE)
    else $error("conversion did not finish after the last bit");

  a_start: assert property (@(posedge clk) disable iff (rst)
    state == bpb_pkg::CV_IDLE && bin_valid && bin_item.byte_count != '0 |=>
    state == bpb_pkg::CV_SHIFT && cnt == CW'(VALUE_WIDTH - 1) && bcd == '0)
    else $error("conversion did not start from a cleared digit register");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == bpb_pkg::CV_DONE |-> count != '0 && count <= NBW'(MAX_BYTES))
    else $error("byte count out of range at hand-off");

endmodule

`default_nettype wire

### rtl/bpb_emit.sv
// Byte serializer: shifts the converted digits out one packed BCD byte per item.
`default_nettype none

module bpb_emit #(
  parameter int MAX_BYTES = 8,
  localparam int DW  = 2 * MAX_BYTES * bpb_pkg::DIGIT_BITS,
  localparam int NBW = $clog2(MAX_BYTES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hand_valid,
  output logic               hand_ready,
  input  logic [DW-1:0]      hand_digits,
  input  logic [NBW-1:0]     hand_count,
  output logic               bcd_valid,
  input  logic               bcd_stall,
  output bpb_pkg::bcd_item_t bcd_item
);

  logic [DW-1:0]      digits, digits_next;
  logic [NBW-1:0]     remaining, remaining_next;
  logic               valid_next;
  bpb_pkg::bcd_item_t item_next;
  logic               load;
  logic               emit;

  assign hand_ready = (remaining == '0);
  assign load       = hand_valid && hand_ready;
  assign emit       = (remaining != '0) && (!bcd_valid || !bcd_stall);

  always_comb begin
    digits_next    = digits;
    remaining_next = remaining;
    valid_next     = bcd_valid;
    item_next      = bcd_item;
    if (load) begin
      digits_next    = hand_digits;
      remaining_next = hand_count;
    end
    if (emit) begin
      digits_next        = digits >> bpb_pkg::BYTE_BITS;
      remaining_next     = remaining - 1'b1;
      valid_next         = 1'b1;
      item_next.bcd_byte = digits[bpb_pkg::BYTE_BITS-1:0];
      item_next.last     = (remaining == NBW'(1));
    end else if (bcd_valid && !bcd_stall) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      bcd_valid <= 1'b0;
    end else begin
      remaining <= remaining_next;
      bcd_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    digits   <= digits_next;
    bcd_item <= item_next;
  end

  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    remaining <= NBW'(MAX_BYTES))
    else $error("remaining byte count exceeds the maximum");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    emit && remaining == NBW'(1) |=> bcd_valid && bcd_item.last)
    else $error("final byte was not marked as last");

endmodule

`default_nettype wire

### rtl/binary_to_packed_bcd_unit.sv
// Top level of the binary to packed BCD converter.
//
// The bin channel takes one item: a binary value and a byte count. The bcd
// channel returns that many packed BCD bytes, least significant byte first,
// each with the lower digit in the low nibble; the final byte has last set.
// A byte count of zero is accepted and produces no bytes, and a count above
// MAX_BYTES is clipped to MAX_BYTES.
// The converter shifts one bit of the value per cycle through the add-3
// digit register. The bytes then leave one per cycle while the bcd channel
// does not stall. The converter hands its digits to the serializer and is
// then ready for the next item, which it converts while the serializer still
// sends the bytes of the last one; with a free output, the serial shift
// through the digit register sets the rate at which items are taken.
// A stall on the bcd channel holds the current byte in the output register;
// the next conversion proceeds meanwhile and waits at the hand-off.
// Reset clears both control paths; no item is in flight afterwards.
`default_nettype none

module binary_to_packed_bcd_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_BYTES   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bin_valid,
  output logic               bin_stall,
  input  bpb_pkg::bin_item_t bin_item,
  output logic               bcd_valid,
  input  logic               bcd_stall,
  output bpb_pkg::bcd_item_t bcd_item
);

  localparam int DW  = 2 * MAX_BYTES * bpb_pkg::DIGIT_BITS;
  localparam int NBW = $clog2(MAX_BYTES + 1);

  logic           hand_valid;
  logic           hand_ready;
  logic [DW-1:0]  hand_digits;
  logic [NBW-1:0] hand_count;

  bpb_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_BYTES   (MAX_BYTES)
  ) u_dabble (
    .clk         (clk),
    .rst         (rst),
    .bin_valid   (bin_valid),
    .bin_stall   (bin_stall),
    .bin_item    (bin_item),
    .hand_valid  (hand_valid),
    .hand_ready  (hand_ready),
    .hand_digits (hand_digits),
    .hand_count  (hand_count)
  );

  bpb_emit #(
    .MAX_BYTES (MAX_BYTES)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .hand_valid  (hand_valid),
    .hand_ready  (hand_ready),
    .hand_digits (hand_digits),
    .hand_count  (hand_count),
    .bcd_valid   (bcd_valid),
    .bcd_stall   (bcd_stall),
    .bcd_item    (bcd_item)
  );

endmodule

`default_nettype wire

### tb/binary_to_packed_bcd_unit_tb.sv
// Self-checking testbench for the binary to packed BCD converter.
module binary_to_packed_bcd_unit_tb;

  localparam int BYTES_MAX    = 8;
  localparam int TAIL_CYCLES  = 100;
  localparam int PHASE_ITEMS  = 137;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    logic [bpb_pkg::VALUE_BITS-1:0] value;
    logic [bpb_pkg::COUNT_BITS-1:0] count;
    logic                           typed;
    logic [63:0]                    digits;
  } vector_t;

  logic               clk;
  logic               rst;
  logic               bin_valid;
  logic               bin_stall;
  bpb_pkg::bin_item_t bin_item;
  logic               bcd_valid;
  logic               bcd_stall;
  bpb_pkg::bcd_item_t bcd_item;

  bpb_pkg::bcd_item_t pending_bytes[$];
  int                 mismatches;
  int                 send_idle_pct;
  int                 stall_pct;

  vector_t directed_vectors [0:NUM_DIRECTED-1] = '{
    '{32'd0,          4'd1,  1'b1, 64'h0},
    '{32'd0,          4'd8,  1'b1, 64'h0},
    '{32'hFFFF_FFFF,  4'd8,  1'b1, 64'h0000_0042_9496_7295},
    '{32'hFFFF_FFFF,  4'd1,  1'b1, 64'h0000_0042_9496_7295},
    '{32'hFFFF_FFFF,  4'd15, 1'b1, 64'h0000_0042_9496_7295},
    '{32'd12345678,   4'd0,  1'b1, 64'h0},
    '{32'd99,         4'd1,  1'b1, 64'h99},
    '{32'd100,        4'd1,  1'b1, 64'h100},
    '{32'd100,        4'd2,  1'b1, 64'h100},
    '{32'hFFFF_FFFE,  4'd8,  1'b1, 64'h0000_0042_9496_7294},
    '{32'd9,          4'd8,  1'b0, 64'h0},
    '{32'd1000000000, 4'd8,  1'b0, 64'h0},
    '{32'd999999999,  4'd5,  1'b0, 64'h0},
    '{32'h8000_0000,  4'd6,  1'b0, 64'h0},
    '{32'd12345678,   4'd4,  1'b0, 64'h0},
    '{32'd42,         4'd9,  1'b0, 64'h0},
    '{32'h5555_5555,  4'd7,  1'b0, 64'h0},
    '{32'hAAAA_AAAA,  4'd3,  1'b0, 64'h0},
    '{32'd7,          4'd0,  1'b1, 64'h0},
    '{32'd10,         4'd2,  1'b0, 64'h0}
  };

  binary_to_packed_bcd_unit dut (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_item  (bin_item),
    .bcd_valid (bcd_valid),
    .bcd_stall (bcd_stall),
    .bcd_item  (bcd_item)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // All sixteen decimal digits of the value, one nibble each, lowest first.
  function automatic logic [63:0] decimal_digits(
    input logic [bpb_pkg::VALUE_BITS-1:0] v
  );
    logic [63:0] digits;
    logic [bpb_pkg::VALUE_BITS-1:0] rest;
    digits = '0;
    rest = v;
    for (int d = 0; d < 16; d++) begin
      digits[4*d +: 4] = 4'(rest % 10);
      rest = rest / 10;
    end
    return digits;
  endfunction

  function automatic logic [bpb_pkg::VALUE_BITS-1:0] pick_value();
    logic [bpb_pkg::VALUE_BITS-1:0] p;
    case ($urandom_range(5))
      0: return $urandom_range(99);
      1: return $urandom >> $urandom_range(31);
      2: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        return p - $urandom_range(1);
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bpb_pkg::COUNT_BITS-1:0] pick_count();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    else if (r == 1) return bpb_pkg::COUNT_BITS'($urandom_range(15, 9));
    else return bpb_pkg::COUNT_BITS'($urandom_range(BYTES_MAX, 1));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic [bpb_pkg::VALUE_BITS-1:0] v,
                           input logic [bpb_pkg::COUNT_BITS-1:0] c,
                           input logic [63:0] digits);
    int gap;
    int n;
    bpb_pkg::bcd_item_t want;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      bin_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_item <= '{value: v, byte_count: c};
    do @(posedge clk); while (bin_stall !== 1'b0);
    n = (c > BYTES_MAX) ? BYTES_MAX : int'(c);
    for (int k = 0; k < n; k++) begin
      want.bcd_byte = digits[8*k +: 8];
      want.last = (k == n - 1);
      pending_bytes.push_back(want);
    end
  endtask

  task automatic drain();
    bin_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic send_random(input int items);
    logic [bpb_pkg::VALUE_BITS-1:0] v;
    for (int i = 0; i < items; i++) begin
      v = pick_value();
      send_item(v, pick_count(), decimal_digits(v));
      if (i == items / 2) drain();
    end
  endtask

  always @(posedge clk) begin
    bcd_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_bytes
    bpb_pkg::bcd_item_t want;
    if (!rst && bcd_valid === 1'b1 && bcd_stall === 1'b0) begin
      if (pending_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h", bcd_item.bcd_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (bcd_item.bcd_byte !== want.bcd_byte)
          flag_mismatch($sformatf("bcd_byte %h, want %h", bcd_item.bcd_byte, want.bcd_byte));
        if (bcd_item.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", bcd_item.last, want.last));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    bin_valid = 1'b0;
    bin_item = '0;
    bcd_stall = 1'b0;
    mismatches = 0;
    send_idle_pct = 31;
    stall_pct = 59;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_vectors[i].value, directed_vectors[i].count,
                directed_vectors[i].typed ? directed_vectors[i].digits
                                          : decimal_digits(directed_vectors[i].value));
    end
    drain();
    send_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 59;
    stall_pct = 31;
    send_random(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    send_random(PHASE_ITEMS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
